// ===== hdl/vqr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqr_pkg: shared types and constants of the 4x4 block frame renderer
// Beat formats, configuration record, command format and sizing constants.
// ----------------------------------------------------------------------------
package vqr_pkg;

  // Codebook index range; a power of two, so an index byte wraps by masking.
  localparam int unsigned CodebookEntries = 256;
  localparam int unsigned MaxDimension    = 4096;
  localparam int unsigned PixelBits       = 32;

  localparam int unsigned CbIdxW     = $clog2(CodebookEntries);
  localparam int unsigned CbAddrW    = 11;
  localparam int unsigned StoreWords = 2048;
  localparam int unsigned SmoothBase = 1024;
  localparam int unsigned DimW       = 13;
  localparam int unsigned BlkCntW    = $clog2(MaxDimension / 4) + 1;
  localparam int unsigned PosW       = 10;
  localparam int unsigned PixPosW    = PosW + 2;
  localparam int unsigned ProdW      = PixPosW + DimW;
  localparam int unsigned PixAddrW   = 24;
  localparam int unsigned WordW      = 32;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);

  localparam logic [WordW-1:0] PixMask = WordW'((64'd1 << PixelBits) - 64'd1);

  typedef enum logic [1:0] {
    REG_INTER_MODE   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_ROW_STRIDE   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    REQ_CB_WRITE    = 2'd0,
    REQ_FRAME_START = 2'd1,
    REQ_STREAM_BYTE = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    CMD_CB_WRITE = 2'd0,
    CMD_DETAIL   = 2'd1,
    CMD_SMOOTH   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [CbAddrW-1:0] cb_addr;
    logic [WordW-1:0]   cb_word;
    logic [7:0]         data_byte;
  } vqr_in_t;

  typedef struct packed {
    logic [PixAddrW-1:0] pix_addr;
    logic [WordW-1:0]    pix_value;
    logic                last_write;
  } vqr_out_t;

  typedef struct packed {
    logic            inter_mode;
    logic [DimW-1:0] frame_width;
    logic [DimW-1:0] frame_height;
    logic [DimW-1:0] row_stride;
  } vqr_cfg_t;

  // One unit of work for the back end: a codebook write or one index to draw.
  typedef struct packed {
    cmd_kind_e          kind;
    logic [CbAddrW-1:0] addr;
    logic [WordW-1:0]   word;
    logic [CbIdxW-1:0]  idx;
    logic [1:0]         quad;
    logic [PosW-1:0]    row;
    logic [PosW-1:0]    col;
  } vqr_cmd_t;

  // Blocks along one dimension: clamp to the maximum, drop the low two bits.
  function automatic logic [BlkCntW-1:0] blocks_of(input logic [DimW-1:0] dim);
    logic [DimW-1:0] clamped;
    clamped = (dim > DimW'(MaxDimension)) ? DimW'(MaxDimension) : dim;
    return BlkCntW'(clamped >> 2);
  endfunction

endpackage

// ===== hdl/vq_block_frame_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vq_block_frame_renderer: vector-quantized 4x4 block frame decoder
// Loads codebooks, parses the flag/index stream and emits pixel writes.
// ----------------------------------------------------------------------------
// Rate: a codebook write takes one input beat per cycle while the command
// queue has room, and an index byte is taken as a single beat. The renderer
// then drives one pixel write beat per cycle while the output is ready, four
// for a detail index and sixteen for a smooth one, so the output port sets
// the sustained rate for index bytes. A frame start, a flag byte and an index
// byte that ends a block each hold the input while the parser resolves flags,
// one flag per cycle: the next flag is taken if one is buffered, and each
// further flag resolved without a byte (a skipped block in inter mode, or the
// flag that picks detail or smooth after a kept block) holds it longer. A
// four-entry command queue sits between parser and renderer, so the parser
// keeps taking beats while pixel writes drain. With an empty queue the
// first pixel beat of an index passes the queue, s1 and output registers.
// Configuration goes through the APB port; change it only between frames.
// Codebook words read before ever being written return unspecified data.
// ----------------------------------------------------------------------------
module vq_block_frame_renderer (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input beats
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vqr_pkg::vqr_in_t  in_data_i,
  // pixel write beats
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vqr_pkg::vqr_out_t out_data_o,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import vqr_pkg::*;

  vqr_cfg_t cfg_q;
  reg_idx_e reg_sel;
  logic     cfg_we;

  logic     cmd_valid, cmd_ready, head_valid, head_pop;
  vqr_cmd_t cmd, head;

  // Register file: zero wait states, written in the access phase.
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_INTER_MODE:   cfg_q.inter_mode   <= pwdata[0];
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[DimW-1:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[DimW-1:0];
        REG_ROW_STRIDE:   cfg_q.row_stride   <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_INTER_MODE:   prdata = 32'(cfg_q.inter_mode);
      REG_FRAME_WIDTH:  prdata = 32'(cfg_q.frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(cfg_q.frame_height);
      REG_ROW_STRIDE:   prdata = 32'(cfg_q.row_stride);
      default:          prdata = '0;
    endcase
  end

  // Parser: flags, block position, phase. Issues one command per index.
  vqr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Decouple parser from pixel output; holds commands in order.
  vqr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .ready_o (cmd_ready),
    .data_i  (cmd),
    .valid_o (head_valid),
    .pop_i   (head_pop),
    .data_o  (head)
  );

  // Renderer: codebook store, address multiply, output register.
  vqr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_stride_i (cfg_q.row_stride),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (head_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== hdl/vqr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqr_front: stream parser
// Tracks flag words, block position and parse phase; issues commands.
// ----------------------------------------------------------------------------
module vqr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vqr_pkg::vqr_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vqr_pkg::vqr_in_t  in_data_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output vqr_pkg::vqr_cmd_t cmd_o
);
  import vqr_pkg::*;

  typedef enum logic [4:0] {
    PH_BLOCK    = 5'b00001,
    PH_CODEFLAG = 5'b00010,
    PH_DETAIL   = 5'b00100,
    PH_SMOOTH   = 5'b01000,
    PH_DONE     = 5'b10000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [WordW-1:0]  shift_q, shift_d;
  logic [5:0]        left_q, left_d;
  logic [1:0]        seen_q, seen_d;
  logic [1:0]        quad_q, quad_d;
  logic [PosW-1:0]   col_q, col_d;
  logic [PosW-1:0]   row_q, row_d;
  logic              settle_q, settle_d;

  logic [BlkCntW-1:0] blk_w, blk_h, col_inc, row_inc;
  logic               outside, nb_wrap, nb_done, flag_bit, accept;
  logic [PosW-1:0]    nb_col, nb_row;

  assign blk_w   = blocks_of(cfg_i.frame_width);
  assign blk_h   = blocks_of(cfg_i.frame_height);
  assign outside = (BlkCntW'(col_q) >= blk_w) || (BlkCntW'(row_q) >= blk_h);

  // Position after the current block.
  assign col_inc = BlkCntW'(col_q) + BlkCntW'(1);
  assign row_inc = BlkCntW'(row_q) + BlkCntW'(1);
  assign nb_wrap = col_inc >= blk_w;
  assign nb_done = nb_wrap && (row_inc >= blk_h);
  assign nb_col  = nb_wrap ? '0 : col_q + PosW'(1);
  assign nb_row  = (nb_wrap && !nb_done) ? row_q + PosW'(1) : row_q;

  assign flag_bit   = shift_q[WordW-1];
  // Hold input while flags resolve, one flag per cycle, or while the queue is full.
  assign in_ready_o = !settle_q && cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d  = phase_q;
    shift_d  = shift_q;
    left_d   = left_q;
    seen_d   = seen_q;
    quad_d   = quad_q;
    col_d    = col_q;
    row_d    = row_q;
    settle_d = settle_q;

    cmd_valid_o = 1'b0;
    cmd_o.kind  = CMD_CB_WRITE;
    cmd_o.addr  = in_data_i.cb_addr;
    cmd_o.word  = in_data_i.cb_word;
    cmd_o.idx   = in_data_i.data_byte[CbIdxW-1:0];
    cmd_o.quad  = quad_q;
    cmd_o.row   = row_q;
    cmd_o.col   = col_q;

    if (settle_q) begin
      unique case (phase_q)
        PH_BLOCK: begin
          if (outside) begin
            phase_d  = PH_DONE;
            settle_d = 1'b0;
          end else if (left_q == '0) begin
            settle_d = 1'b0;
          end else begin
            shift_d = shift_q << 1;
            left_d  = left_q - 6'd1;
            if (cfg_i.inter_mode) begin
              if (flag_bit) begin
                phase_d = PH_CODEFLAG;
              end else begin
                // Skipped block: advance and keep resolving.
                col_d   = nb_col;
                row_d   = nb_row;
                phase_d = nb_done ? PH_DONE : PH_BLOCK;
              end
            end else begin
              phase_d  = flag_bit ? PH_DETAIL : PH_SMOOTH;
              quad_d   = '0;
              settle_d = 1'b0;
            end
          end
        end
        PH_CODEFLAG: begin
          if (left_q != '0) begin
            shift_d = shift_q << 1;
            left_d  = left_q - 6'd1;
            phase_d = flag_bit ? PH_DETAIL : PH_SMOOTH;
            quad_d  = '0;
          end
          settle_d = 1'b0;
        end
        default: settle_d = 1'b0;
      endcase
    end else if (accept) begin
      unique case (in_data_i.req_type)
        REQ_CB_WRITE: begin
          cmd_valid_o = 1'b1;
          cmd_o.kind  = CMD_CB_WRITE;
        end
        REQ_FRAME_START: begin
          phase_d  = PH_BLOCK;
          shift_d  = '0;
          left_d   = '0;
          seen_d   = '0;
          quad_d   = '0;
          col_d    = '0;
          row_d    = '0;
          settle_d = 1'b1;
        end
        REQ_STREAM_BYTE: begin
          if (phase_q != PH_DONE && outside) begin
            phase_d = PH_DONE;
          end else begin
            unique case (phase_q) inside
              PH_BLOCK, PH_CODEFLAG: begin
                shift_d = {shift_q[WordW-9:0], in_data_i.data_byte};
                seen_d  = seen_q + 2'd1;
                if (seen_q == 2'd3) begin
                  left_d = 6'd32;
                end
                settle_d = 1'b1;
              end
              PH_DETAIL: begin
                cmd_valid_o = 1'b1;
                cmd_o.kind  = CMD_DETAIL;
                quad_d      = quad_q + 2'd1;
                if (quad_q == 2'd3) begin
                  col_d    = nb_col;
                  row_d    = nb_row;
                  phase_d  = nb_done ? PH_DONE : PH_BLOCK;
                  settle_d = 1'b1;
                end
              end
              PH_SMOOTH: begin
                cmd_valid_o = 1'b1;
                cmd_o.kind  = CMD_SMOOTH;
                quad_d      = '0;
                col_d       = nb_col;
                row_d       = nb_row;
                phase_d     = nb_done ? PH_DONE : PH_BLOCK;
                settle_d    = 1'b1;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_BLOCK;
      shift_q  <= '0;
      left_q   <= '0;
      seen_q   <= '0;
      quad_q   <= '0;
      col_q    <= '0;
      row_q    <= '0;
      settle_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      shift_q  <= shift_d;
      left_q   <= left_d;
      seen_q   <= seen_d;
      quad_q   <= quad_d;
      col_q    <= col_d;
      row_q    <= row_d;
      settle_q <= settle_d;
    end
  end

  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= 6'd32)
    else $error("flag count above one word");

  a_done_stops_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settle_q && phase_q == PH_DONE |=> !settle_q)
    else $error("flag resolution kept running after frame end");

  a_quad_in_detail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quad_q != 2'd0 |-> (phase_q == PH_DETAIL || phase_q == PH_DONE))
    else $error("quadrant count left over outside detail phase");

endmodule

// ===== hdl/vqr_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqr_cmd_fifo: command queue between parser and renderer
// Small register queue; lets either side stall on its own.
// ----------------------------------------------------------------------------
module vqr_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              ready_o,
  input  vqr_pkg::vqr_cmd_t data_i,
  output logic              valid_o,
  input  logic              pop_i,
  output vqr_pkg::vqr_cmd_t data_o
);
  import vqr_pkg::*;

  vqr_cmd_t            slot_q [FifoDepth];
  logic [FifoPtrW-1:0] wptr_q, rptr_q;
  logic [FifoPtrW:0]   count_q;

  assign ready_o = count_q != (FifoPtrW + 1)'(FifoDepth);
  assign valid_o = count_q != '0;
  assign data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + FifoPtrW'(1);
      end
      count_q <= count_q + (FifoPtrW + 1)'(push_i) - (FifoPtrW + 1)'(pop_i);
    end
  end

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command popped from empty queue");

endmodule

// ===== hdl/vqr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqr_back: block renderer
// Owns the codebook store; expands commands into pixel write beats.
// ----------------------------------------------------------------------------
module vqr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [vqr_pkg::DimW-1:0]    row_stride_i,
  input  logic                        head_valid_i,
  input  vqr_pkg::vqr_cmd_t           head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output vqr_pkg::vqr_out_t           out_data_o
);
  import vqr_pkg::*;

  logic [WordW-1:0]   store_q [StoreWords];
  logic [WordW-1:0]   rdata_q;
  logic [3:0]         k_q, k_d;
  logic               adv, is_write, is_detail, is_smooth, issue, final_pix;
  logic [1:0]         dy, dx;
  logic [CbAddrW-1:0] rd_addr;
  logic [PixPosW-1:0] row_pix, col_pix;
  logic [ProdW-1:0]   prod;

  logic               s1_valid_q;
  logic [ProdW-1:0]   s1_prod_q;
  logic [PixPosW-1:0] s1_col_q;
  logic               s1_last_q;
  logic               out_valid_q;
  vqr_out_t           out_data_q;

  assign adv       = !out_valid_q || out_ready_i;
  assign is_write  = head_valid_i && head_i.kind == CMD_CB_WRITE;
  assign is_detail = head_valid_i && head_i.kind == CMD_DETAIL;
  assign is_smooth = head_valid_i && head_i.kind == CMD_SMOOTH;
  assign issue     = adv && (is_detail || is_smooth);
  assign final_pix = is_detail ? (k_q[1:0] == 2'b11) : (k_q == 4'hF);
  assign pop_o     = is_write || (issue && final_pix);

  // Detail: four pixels of one quadrant. Smooth: quadrant by quadrant.
  always_comb begin
    if (is_detail) begin
      dy      = {head_i.quad[1], k_q[1]};
      dx      = {head_i.quad[0], k_q[0]};
      rd_addr = CbAddrW'({head_i.idx, k_q[1:0]});
    end else begin
      dy      = {k_q[3], k_q[1]};
      dx      = {k_q[2], k_q[0]};
      rd_addr = CbAddrW'(SmoothBase) | CbAddrW'({head_i.idx, k_q[3:2]});
    end
  end

  assign row_pix = {head_i.row, dy};
  assign col_pix = {head_i.col, dx};
  assign prod    = ProdW'(row_pix) * ProdW'(row_stride_i);

  always_comb begin
    k_d = k_q;
    if (pop_o) begin
      k_d = '0;
    end else if (issue) begin
      k_d = k_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_write) begin
      store_q[head_i.addr] <= head_i.word;
    end
    if (issue) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_prod_q <= prod;
      s1_col_q  <= col_pix;
      s1_last_q <= final_pix;
    end
    if (adv && s1_valid_q) begin
      out_data_q.pix_addr   <= PixAddrW'(s1_prod_q + ProdW'(s1_col_q));
      out_data_q.pix_value  <= rdata_q & PixMask;
      out_data_q.last_write <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      k_q <= k_d;
      if (adv) begin
        s1_valid_q  <= issue;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_detail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_detail |-> k_q[3:2] == 2'b00)
    else $error("detail command ran past four pixels");

  a_write_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_write |-> k_q == 4'd0)
    else $error("codebook write reached with pixel count in flight");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 4x4 block frame renderer
// Loads codebooks, decodes directed and random flag/index streams in intra
// and inter mode, and checks every pixel write beat against a cycle-free
// predictor that mirrors codebook, flag buffer and block position.
// ----------------------------------------------------------------------------
module tb_top;
  import vqr_pkg::*;

  // Undefined request code; the block must drop it without a result.
  localparam logic [1:0] ReqUndefined = 2'd3;
  // Quiet cycles after the last pixel write before touching registers or
  // ending: covers flag resolution (one flag per cycle) plus pipeline depth.
  localparam int unsigned SettleCycles = 64;
  // Cycles without any accepted beat that count as a hang.
  localparam int unsigned StuckLimit   = 2000;
  localparam int unsigned RandomBeats  = 10;

  typedef enum logic [2:0] {
    PARSE_BLOCK,
    PARSE_CODEFLAG,
    PARSE_DETAIL,
    PARSE_SMOOTH,
    PARSE_DONE
  } parse_e;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  vqr_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  vqr_out_t out_data;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  vq_block_frame_renderer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: codebook mirror, flag buffer, parse phase, position and
  // the register values as last written.
  // --------------------------------------------------------------------------
  logic [WordW-1:0] cb_mirror [StoreWords];
  logic [31:0]      flag_word;
  int unsigned      flags_avail;
  logic [1:0]       flag_bytes;
  parse_e           parse_at;
  logic [1:0]       quad_at;
  int unsigned      blk_col;
  int unsigned      blk_row;
  vqr_cfg_t         cfg_now;

  vqr_out_t    pixel_writes_due[$];  // pixel write beats still to arrive
  logic [7:0]  drawable_idx[$];      // indexes whose detail and smooth words are loaded
  int unsigned mismatches      = 0;
  int unsigned effective_beats = 0;  // beats that changed state or drew pixels
  bit          idle_on         = 1'b1;
  int unsigned stall_left      = 0;
  int unsigned stuck_cycles    = 0;

  function automatic int unsigned blocks_along(logic [DimW-1:0] dim);
    int unsigned d;
    d = 32'(dim);
    if (d > MaxDimension) d = MaxDimension;
    return d >> 2;
  endfunction

  function automatic bit past_frame_edge();
    return blk_col >= blocks_along(cfg_now.frame_width) ||
           blk_row >= blocks_along(cfg_now.frame_height);
  endfunction

  // Shift out the next flag, MSB first.
  function automatic bit pop_flag();
    bit b;
    b = flag_word[31];
    flag_word = flag_word << 1;
    flags_avail = flags_avail - 1;
    return b;
  endfunction

  // Move left to right, then down; past the last row the frame is done.
  function automatic void advance_block();
    blk_col++;
    if (blk_col >= blocks_along(cfg_now.frame_width)) begin
      blk_col = 0;
      if (blk_row + 1 >= blocks_along(cfg_now.frame_height)) parse_at = PARSE_DONE;
      else blk_row++;
    end
  endfunction

  // Resolve every flag that needs no further byte: skips in inter mode and
  // the detail/smooth choice.
  function automatic void resolve_flags();
    while (parse_at != PARSE_DONE) begin
      if (parse_at == PARSE_BLOCK) begin
        if (past_frame_edge()) begin
          parse_at = PARSE_DONE;
          return;
        end
        if (flags_avail == 0) return;
        if (cfg_now.inter_mode) begin
          if (pop_flag()) parse_at = PARSE_CODEFLAG;
          else advance_block();
        end else begin
          parse_at = pop_flag() ? PARSE_DETAIL : PARSE_SMOOTH;
          quad_at = 2'd0;
          return;
        end
      end else if (parse_at == PARSE_CODEFLAG) begin
        if (flags_avail == 0) return;
        parse_at = pop_flag() ? PARSE_DETAIL : PARSE_SMOOTH;
        quad_at = 2'd0;
        return;
      end else begin
        return;
      end
    end
  endfunction

  function automatic void draw_pixel(int unsigned dy, int unsigned dx,
                                     logic [WordW-1:0] value, bit last);
    int unsigned row;
    int unsigned col;
    logic [31:0] lin;
    vqr_out_t    w;
    row = blk_row * 4 + dy;
    col = blk_col * 4 + dx;
    lin = row * cfg_now.row_stride + col;
    w.pix_addr   = lin[PixAddrW-1:0];
    w.pix_value  = value & PixMask;
    w.last_write = last;
    pixel_writes_due.push_back(w);
  endfunction

  // Apply one accepted input beat; queue the pixel writes it causes. Return
  // whether the beat did anything at all.
  function automatic bit render_step(vqr_in_t beat);
    int unsigned idx;
    int unsigned q;
    logic [WordW-1:0] v;
    case (beat.req_type)
      REQ_CB_WRITE: begin
        cb_mirror[beat.cb_addr] = beat.cb_word;
        return 1'b1;
      end
      REQ_FRAME_START: begin
        flag_word   = '0;
        flags_avail = 0;
        flag_bytes  = '0;
        parse_at    = PARSE_BLOCK;
        quad_at     = '0;
        blk_col     = 0;
        blk_row     = 0;
        resolve_flags();
        return 1'b1;
      end
      REQ_STREAM_BYTE: ;
      default: return 1'b0;
    endcase

    // A register change may have left the position outside the frame.
    if (parse_at != PARSE_DONE && past_frame_edge()) parse_at = PARSE_DONE;
    idx = beat.data_byte % CodebookEntries;
    case (parse_at)
      PARSE_BLOCK, PARSE_CODEFLAG: begin
        flag_word  = {flag_word[23:0], beat.data_byte};
        flag_bytes = flag_bytes + 2'd1;
        if (flag_bytes == 2'd0) flags_avail = 32;
        resolve_flags();
      end
      PARSE_DETAIL: begin
        q = 32'(quad_at);
        for (int unsigned k = 0; k < 4; k++)
          draw_pixel((q >> 1) * 2 + (k >> 1), (q & 1) * 2 + (k & 1),
                     cb_mirror[(idx * 4 + k) % StoreWords], k == 3);
        quad_at = quad_at + 2'd1;
        if (q == 3) begin
          parse_at = PARSE_BLOCK;
          advance_block();
          resolve_flags();
        end
      end
      PARSE_SMOOTH: begin
        for (q = 0; q < 4; q++) begin
          v = cb_mirror[(SmoothBase + idx * 4 + q) % StoreWords];
          for (int unsigned k = 0; k < 4; k++)
            draw_pixel((q >> 1) * 2 + (k >> 1), (q & 1) * 2 + (k & 1), v,
                       q == 3 && k == 3);
        end
        quad_at  = '0;
        parse_at = PARSE_BLOCK;
        advance_block();
        resolve_flags();
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stall bursts, then the comparison of each beat
  // against the oldest expected pixel write.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(string what);
    $display("[%0t] pixel write mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_pixels
    vqr_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pixel_writes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat addr %h value %h",
                                  out_data.pix_addr, out_data.pix_value));
      end else begin
        want = pixel_writes_due.pop_front();
        if (out_data.pix_addr !== want.pix_addr)
          report_mismatch($sformatf("pix_addr got %h want %h",
                                    out_data.pix_addr, want.pix_addr));
        if (out_data.pix_value !== want.pix_value)
          report_mismatch($sformatf("pix_value got %h want %h (addr %h)",
                                    out_data.pix_value, want.pix_value, want.pix_addr));
        if (out_data.last_write !== want.last_write)
          report_mismatch($sformatf("last_write got %b want %b (addr %h)",
                                    out_data.last_write, want.last_write, want.pix_addr));
      end
    end
  end

  // Watchdog: any beat on either channel or a register access counts as
  // progress; a long silence means the block hung.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == StuckLimit) begin
      $display("[%0t] no beat accepted for %0d cycles", $time, StuckLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Send one input beat and predict its effect once accepted. Valid is only
  // dropped for an idle gap, so back-to-back beats keep it high.
  task automatic send_beat(logic [1:0] kind, logic [CbAddrW-1:0] addr,
                           logic [WordW-1:0] word, logic [7:0] value);
    vqr_in_t beat;
    beat = '{req_type: kind, cb_addr: addr, cb_word: word, data_byte: value};
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (!in_ready);
    effective_beats += render_step(beat);
  endtask

  task automatic send_byte(logic [7:0] value);
    send_beat(REQ_STREAM_BYTE, CbAddrW'($urandom), $urandom, value);
  endtask

  task automatic send_frame_start();
    send_beat(REQ_FRAME_START, CbAddrW'($urandom), $urandom, 8'($urandom));
  endtask

  function automatic logic [7:0] pick_drawable();
    return drawable_idx[$urandom_range(0, drawable_idx.size() - 1)];
  endfunction

  // Index bytes only ever name loaded entries; flag bytes lean on the
  // all-clear and all-set patterns now and then.
  function automatic logic [7:0] next_stream_byte();
    if (parse_at == PARSE_DETAIL || parse_at == PARSE_SMOOTH) return pick_drawable();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Drop valid, let every expected pixel write land, then let the parser
  // finish flag work that produces no beat.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pixel_writes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Setup phase, then access phase; the register takes the value at the
  // edge that closes the access. Select is released by the caller.
  task automatic reg_write(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_INTER_MODE:   cfg_now.inter_mode   = value[0];
      REG_FRAME_WIDTH:  cfg_now.frame_width  = value[DimW-1:0];
      REG_FRAME_HEIGHT: cfg_now.frame_height = value[DimW-1:0];
      REG_ROW_STRIDE:   cfg_now.row_stride   = value[DimW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(bit inter, int unsigned w, int unsigned h,
                                int unsigned stride);
    reg_write(REG_INTER_MODE, 32'(inter));
    reg_write(REG_FRAME_WIDTH, w);
    reg_write(REG_FRAME_HEIGHT, h);
    reg_write(REG_ROW_STRIDE, stride);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Load detail and smooth words for a handful of indexes, the extremes
  // among them; index 0 gets all-zero detail words, index 255 all-one smooth
  // words. An undefined request code goes in as well.
  task automatic test_codebook_load();
    int unsigned idx;
    logic [WordW-1:0] dw;
    logic [WordW-1:0] sw;
    drawable_idx = '{8'h00, 8'hFF, 8'h55, 8'hAA};
    repeat (1) drawable_idx.push_back(8'($urandom));
    foreach (drawable_idx[i]) begin
      idx = 32'(drawable_idx[i]);
      for (int unsigned k = 0; k < 4; k++) begin
        dw = (idx == 0) ? '0 : $urandom;
        sw = (idx == 255) ? '1 : $urandom;
        send_beat(REQ_CB_WRITE, CbAddrW'(idx * 4 + k), dw, 8'($urandom));
        send_beat(REQ_CB_WRITE, CbAddrW'(SmoothBase + idx * 4 + k), sw, 8'($urandom));
      end
    end
    send_beat(ReqUndefined, CbAddrW'($urandom), $urandom, 8'($urandom));
  endtask

  // 2x2 blocks, intra: detail, smooth, detail, smooth, then a byte past the
  // last block that must be dropped.
  task automatic test_intra_frame();
    wait_idle();
    apply_settings(1'b0, 8, 8, 8);
    send_frame_start();
    send_byte(8'hA0);
    repeat (3) send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'hFF);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // Three blocks in a row, inter: skip, keep+detail, keep+smooth; stride 0
  // folds every row onto the same addresses.
  task automatic test_inter_frame();
    wait_idle();
    apply_settings(1'b1, 12, 4, 0);
    send_frame_start();
    send_byte(8'h70);
    repeat (3) send_byte(8'h00);
    repeat (5) send_byte(pick_drawable());
  endtask

  // Width below one block: the frame is over before it starts.
  task automatic test_empty_frame();
    wait_idle();
    apply_settings(1'b0, 3, 8, 8);
    send_frame_start();
    send_byte(8'h5A);
  endtask

  // Shrink the width mid-frame so the position falls outside; the next
  // byte is dropped. A new frame then decodes under the new width.
  task automatic test_resize_mid_frame();
    wait_idle();
    apply_settings(1'b0, 16, 8, 16);
    send_frame_start();
    repeat (4) send_byte(8'h00);
    send_byte(pick_drawable());
    wait_idle();
    apply_settings(1'b0, 4, 8, 16);
    send_byte(pick_drawable());
    send_frame_start();
    send_byte(8'h80);
    repeat (3) send_byte(8'h00);
    repeat (5) send_byte(pick_drawable());
  endtask

  // Oversized height saturates; skip 520 blocks of a one-column frame with
  // the widest stride so the drawn block lands beyond the 24-bit range.
  task automatic test_address_wrap();
    wait_idle();
    apply_settings(1'b1, 4, 8191, 8191);
    send_frame_start();
    repeat (65) send_byte(8'h00);
    send_byte(8'hC0);
    repeat (2) send_byte(8'h00);
    repeat (4) send_byte(pick_drawable());
  endtask

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 15))
      0:       return $urandom_range(0, 3);
      1:       return MaxDimension;
      2:       return $urandom_range(MaxDimension + 1, 8191);
      default: return $urandom_range(4, 16);
    endcase
  endfunction

  // Mostly well-formed frames under random settings; noise beats, codebook
  // rewrites and early frame starts break some of them up.
  task automatic test_random_frames();
    int unsigned goal;
    int unsigned frame_len;
    int unsigned stride;
    goal = effective_beats + RandomBeats;
    while (effective_beats < goal) begin
      wait_idle();
      if (effective_beats + 5 >= goal) idle_on = 1'b0;
      case ($urandom_range(0, 3))
        0:       stride = 0;
        1:       stride = 8191;
        default: stride = $urandom_range(0, 8191);
      endcase
      apply_settings(1'($urandom_range(0, 1)), pick_dim(), pick_dim(), stride);
      repeat ($urandom_range(0, 2))
        send_beat(REQ_CB_WRITE,
                  CbAddrW'(($urandom_range(0, 1) ? SmoothBase : 0) +
                           pick_drawable() * 4 + $urandom_range(0, 3)),
                  $urandom, 8'($urandom));
      send_frame_start();
      frame_len = $urandom_range(8, 48);
      for (int unsigned n = 0; n < frame_len; n++) begin
        if (parse_at == PARSE_DONE && $urandom_range(0, 3) != 0) break;
        case ($urandom_range(0, 29))
          0: send_beat(ReqUndefined, CbAddrW'($urandom), $urandom, 8'($urandom));
          1: send_beat(REQ_CB_WRITE, CbAddrW'($urandom), $urandom, 8'($urandom));
          2: send_frame_start();
          default: send_byte(next_stream_byte());
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_now     = '0;
    flag_word   = '0;
    flags_avail = 0;
    flag_bytes  = '0;
    parse_at    = PARSE_BLOCK;
    quad_at     = '0;
    blk_col     = 0;
    blk_row     = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_codebook_load();
    test_intra_frame();
    test_inter_frame();
    test_empty_frame();
    test_resize_mid_frame();
    test_address_wrap();
    test_random_frames();

    // Drain: every expected beat in, then a quiet tail for stray writes.
    wait_idle();
    if (mismatches == 0 && pixel_writes_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
